// File: hw/rtl/sdtq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdtq_pkg
// Shared types, constants and helpers of the sorted deadline timer queue.
// ---------------------------------------------------------------------------
package sdtq_pkg;

  // store geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int STAMP_W  = 64;
  localparam int REPORT_W = 5;

  typedef logic [STAMP_W-1:0]  stamp_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [REPORT_W-1:0] report_t;

  // action codes
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_FIRE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_DUP  = 2'd2,
    STAT_FULL = 2'd3
  } status_t;

  // store write selection
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_COMPACT,
    WR_INSERT
  } wr_sel_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_COMPACT,
    ST_COMPACT_WR,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    rd;
    logic    scan_adv;
    logic    scan_stop;
    logic    idx_top;
    logic    idx_dec;
    logic    idx_inc;
    wr_sel_t wr_sel;
    logic    commit;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_fire;
    logic zero_ddl;
    logic at_end;
    logic hit;
    logic eq_held;
    logic full;
    logic at_pos;
    logic pos_at_end;
  } dp_stat_t;

  // count reported in five bits, masked when the store is deeper
  function automatic report_t to_report(cnt_t c);
    logic [CNT_W+REPORT_W-1:0] ext;
    ext = {{REPORT_W{1'b0}}, c};
    return ext[REPORT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/sdtq_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdtq_if
// Valid/ready channels of the deadline queue: item in, result out.
// ---------------------------------------------------------------------------
interface sdtq_in_if;
  logic            valid;
  logic            ready;
  logic            action;
  sdtq_pkg::stamp_t deadline;
  sdtq_pkg::stamp_t now;

  modport source (output valid, output action, output deadline, output now, input ready);
  modport sink   (input valid, input action, input deadline, input now, output ready);
endinterface

interface sdtq_out_if;
  logic              valid;
  logic              ready;
  logic              armed_valid;
  sdtq_pkg::stamp_t  armed_deadline;
  logic [1:0]        status;
  sdtq_pkg::report_t expired_count;
  sdtq_pkg::report_t pending_count;

  modport source (output valid, output armed_valid, output armed_deadline, output status,
                  output expired_count, output pending_count, input ready);
  modport sink   (input valid, input armed_valid, input armed_deadline, input status,
                  input expired_count, input pending_count, output ready);
endinterface

// File: hw/rtl/sorted_deadline_timer_queue_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_deadline_timer_queue_unit
// Sorted queue of pending 64-bit timer deadlines with earliest-deadline arm.
// ---------------------------------------------------------------------------
// One item at a time. An add walks the sorted store to find its place (the
// store has one port with registered read data), then moves every later
// entry up one slot and writes the new deadline; a fire walks the expired
// entries and moves the survivors down. A full store never shifts, and a
// zero add skips the walk. The finished result sits in an output register,
// so the next item is taken while it waits. After reset the queue is empty
// and disarmed; no clearing pass is needed.
module sorted_deadline_timer_queue_unit (
  input  logic       clk,
  input  logic       rst_n,
  sdtq_in_if.sink    in_ch,
  sdtq_out_if.source out_ch
);

  sdtq_pkg::dp_cmd_t  cmd;
  sdtq_pkg::dp_stat_t stat;

  // sequencer
  sdtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store and arithmetic
  sdtq_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_ch.action),
    .in_deadline        (in_ch.deadline),
    .in_now             (in_ch.now),
    .out_armed_valid    (out_ch.armed_valid),
    .out_armed_deadline (out_ch.armed_deadline),
    .out_status         (out_ch.status),
    .out_expired_count  (out_ch.expired_count),
    .out_pending_count  (out_ch.pending_count)
  );

endmodule

// File: hw/rtl/sdtq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdtq_ctrl
// Sequencer of the deadline queue: scan, shift or compact, then report.
// ---------------------------------------------------------------------------
module sdtq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sdtq_pkg::dp_stat_t stat,
  output sdtq_pkg::dp_cmd_t  cmd
);

  sdtq_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdtq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.wr_sel    = sdtq_pkg::WR_NONE;
    case (state_r)
      sdtq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sdtq_pkg::ST_SCAN;
        end
      end
      sdtq_pkg::ST_SCAN: begin
        if (!stat.is_fire && stat.zero_ddl) begin
          state_nxt = sdtq_pkg::ST_FINISH;
        end else if (stat.at_end) begin
          cmd.scan_stop = 1'b1;
          state_nxt     = stat.is_fire ? sdtq_pkg::ST_COMPACT : sdtq_pkg::ST_DECIDE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = sdtq_pkg::ST_SCAN_CHK;
        end
      end
      sdtq_pkg::ST_SCAN_CHK: begin
        if (stat.hit) begin
          cmd.scan_adv = 1'b1;
          state_nxt    = sdtq_pkg::ST_SCAN;
        end else begin
          cmd.scan_stop = 1'b1;
          state_nxt     = stat.is_fire ? sdtq_pkg::ST_COMPACT : sdtq_pkg::ST_DECIDE;
        end
      end
      sdtq_pkg::ST_DECIDE: begin
        if (stat.eq_held || stat.full) begin
          state_nxt = sdtq_pkg::ST_FINISH;
        end else if (stat.pos_at_end) begin
          state_nxt = sdtq_pkg::ST_INSERT;
        end else begin
          cmd.idx_top = 1'b1;
          state_nxt   = sdtq_pkg::ST_SHIFT_RD;
        end
      end
      // move entries up by one, from the top down to the insert point
      sdtq_pkg::ST_SHIFT_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = sdtq_pkg::ST_SHIFT_WR;
      end
      sdtq_pkg::ST_SHIFT_WR: begin
        cmd.wr_sel = sdtq_pkg::WR_SHIFT;
        if (stat.at_pos) begin
          state_nxt = sdtq_pkg::ST_INSERT;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = sdtq_pkg::ST_SHIFT_RD;
        end
      end
      sdtq_pkg::ST_INSERT: begin
        cmd.wr_sel = sdtq_pkg::WR_INSERT;
        state_nxt  = sdtq_pkg::ST_FINISH;
      end
      // move surviving entries down over the expired ones
      sdtq_pkg::ST_COMPACT: begin
        if (stat.at_end) begin
          state_nxt = sdtq_pkg::ST_FINISH;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = sdtq_pkg::ST_COMPACT_WR;
        end
      end
      sdtq_pkg::ST_COMPACT_WR: begin
        cmd.wr_sel  = sdtq_pkg::WR_COMPACT;
        cmd.idx_inc = 1'b1;
        state_nxt   = sdtq_pkg::ST_COMPACT;
      end
      // commit once the result register is free
      sdtq_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sdtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sdtq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/sdtq_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdtq_dp
// Datapath of the deadline queue: sorted store, scan compare, armed state.
// ---------------------------------------------------------------------------
module sdtq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sdtq_pkg::dp_cmd_t  cmd,
  output sdtq_pkg::dp_stat_t stat,
  input  logic               in_action,
  input  sdtq_pkg::stamp_t   in_deadline,
  input  sdtq_pkg::stamp_t   in_now,
  output logic               out_armed_valid,
  output sdtq_pkg::stamp_t   out_armed_deadline,
  output logic [1:0]         out_status,
  output sdtq_pkg::report_t  out_expired_count,
  output sdtq_pkg::report_t  out_pending_count
);

  // sorted deadline store
  sdtq_pkg::stamp_t mem [sdtq_pkg::QUEUE_DEPTH];

  // item fields
  logic             action_r;
  sdtq_pkg::stamp_t deadline_r;
  sdtq_pkg::stamp_t now_r;

  // walk state
  sdtq_pkg::cnt_t   idx_r;
  sdtq_pkg::cnt_t   pos_r;
  logic             eq_r;
  sdtq_pkg::stamp_t head_r;
  sdtq_pkg::stamp_t rd_data_r;

  // queue state
  sdtq_pkg::cnt_t   count_r, count_nxt;
  sdtq_pkg::stamp_t armed_r, armed_nxt;
  logic             flag_r, flag_nxt;
  sdtq_pkg::status_t status_c;

  sdtq_pkg::cnt_t   idx_up;
  sdtq_pkg::cnt_t   idx_down;
  logic             hit_c;
  logic             wr_en;
  sdtq_pkg::idx_t   wr_addr;
  sdtq_pkg::stamp_t wr_data;

  assign idx_up   = idx_r + 1'b1;
  assign idx_down = idx_r - pos_r;

  // scan compare: fire walks over entries at or below now, add over smaller ones
  assign hit_c = action_r ? (rd_data_r <= now_r) : (rd_data_r < deadline_r);

  always_comb begin
    stat            = '0;
    stat.is_fire    = (action_r == sdtq_pkg::ACT_FIRE);
    stat.zero_ddl   = (deadline_r == '0);
    stat.at_end     = (idx_r == count_r);
    stat.hit        = hit_c;
    stat.eq_held    = eq_r;
    stat.full       = (count_r == sdtq_pkg::CNT_W'(sdtq_pkg::QUEUE_DEPTH));
    stat.at_pos     = (idx_r == pos_r);
    stat.pos_at_end = (pos_r == count_r);
  end

  // store write port selection
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_r[sdtq_pkg::IDX_W-1:0];
    wr_data = rd_data_r;
    case (cmd.wr_sel)
      sdtq_pkg::WR_SHIFT:   wr_addr = idx_up[sdtq_pkg::IDX_W-1:0];
      sdtq_pkg::WR_COMPACT: wr_addr = idx_down[sdtq_pkg::IDX_W-1:0];
      sdtq_pkg::WR_INSERT: begin
        wr_addr = pos_r[sdtq_pkg::IDX_W-1:0];
        wr_data = deadline_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[idx_r[sdtq_pkg::IDX_W-1:0]];
    end
  end

  // item capture and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r   <= in_action;
      deadline_r <= in_deadline;
      now_r      <= in_now;
    end
    if (cmd.scan_stop) begin
      pos_r  <= idx_r;
      eq_r   <= !stat.at_end && (rd_data_r == deadline_r);
      head_r <= rd_data_r;
    end
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.idx_top) begin
      idx_r <= count_r - 1'b1;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - 1'b1;
    end else if (cmd.scan_adv || cmd.idx_inc) begin
      idx_r <= idx_up;
    end
  end

  // status of the finished item
  always_comb begin
    if (action_r == sdtq_pkg::ACT_FIRE) status_c = sdtq_pkg::STAT_OK;
    else if (deadline_r == '0)          status_c = sdtq_pkg::STAT_ZERO;
    else if (eq_r)                      status_c = sdtq_pkg::STAT_DUP;
    else if (stat.full)                 status_c = sdtq_pkg::STAT_FULL;
    else                                status_c = sdtq_pkg::STAT_OK;
  end

  // queue state after the item
  always_comb begin
    count_nxt = count_r;
    armed_nxt = armed_r;
    flag_nxt  = flag_r;
    if (action_r == sdtq_pkg::ACT_FIRE) begin
      count_nxt = count_r - pos_r;
      if (pos_r != count_r) begin
        armed_nxt = head_r;
        flag_nxt  = 1'b1;
      end else begin
        armed_nxt = '0;
        flag_nxt  = 1'b0;
      end
    end else if (status_c == sdtq_pkg::STAT_OK) begin
      count_nxt = count_r + 1'b1;
      flag_nxt  = 1'b1;
      if (pos_r == '0) begin
        armed_nxt = deadline_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      armed_r <= '0;
      flag_r  <= 1'b0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
      armed_r <= armed_nxt;
      flag_r  <= flag_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_armed_valid    <= flag_nxt;
      out_armed_deadline <= armed_nxt;
      out_status         <= status_c;
      out_expired_count  <= action_r ? sdtq_pkg::to_report(pos_r) : '0;
      out_pending_count  <= sdtq_pkg::to_report(count_nxt);
    end
  end

endmodule

// File: hw/rtl/sdtq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdtq_checker
// Port-level checks of the deadline queue, bound to the top level.
// ---------------------------------------------------------------------------
module sdtq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              armed_valid,
  input sdtq_pkg::stamp_t  armed_deadline,
  input logic [1:0]        status,
  input sdtq_pkg::report_t expired_count,
  input sdtq_pkg::report_t pending_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(armed_deadline) && $stable(pending_count))
    else $error("result changed while stalled");

  // one item in flight: busy right after a transfer in
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // armed exactly when something is pending
  a_armed_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (armed_valid == (pending_count != '0)))
    else $error("armed flag disagrees with pending count");

  // disarmed shows a zero deadline
  a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !armed_valid |-> armed_deadline == '0)
    else $error("disarmed result carries a deadline");

  // only a fire expires entries, and a rejected add expires none
  a_reject_no_expire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != 2'(sdtq_pkg::STAT_OK)) |-> expired_count == '0)
    else $error("rejected add reports expired entries");

endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .armed_valid    (out_ch.armed_valid),
  .armed_deadline (out_ch.armed_deadline),
  .status         (out_ch.status),
  .expired_count  (out_ch.expired_count),
  .pending_count  (out_ch.pending_count)
);

// File: tb/sdtq_queue_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdtq_queue_check
// Predicts and checks every result of the sorted deadline timer queue.
// ---------------------------------------------------------------------------
// Watches both channels. Each item transfer runs through a behavioral copy of
// the sorted deadline store, and the report it should give is queued. Each
// result transfer is compared field by field with the oldest queued report.
// The failure count and the number of reports still due go to the bench top.
module sdtq_queue_check (
  input  logic clk,
  input  logic rst_n,
  sdtq_in_if   in_mon,
  sdtq_out_if  out_mon,
  output int   fail_count,
  output int   outstanding,
  output int   checked_count,
  output int   full_count
);

  typedef struct packed {
    logic              armed_valid;
    sdtq_pkg::stamp_t  armed_deadline;
    sdtq_pkg::status_t status;
    sdtq_pkg::report_t expired_count;
    sdtq_pkg::report_t pending_count;
  } timer_report_t;

  // behavioral copy of the store and the comparator arm
  sdtq_pkg::stamp_t held_ddl [sdtq_pkg::QUEUE_DEPTH];
  int               held_cnt;
  logic             armed_q;
  sdtq_pkg::stamp_t armed_ddl_q;

  timer_report_t due_reports[$];
  int            errs;
  int            checks;
  int            fulls;

  // insert or expire deadlines, then report what the block should show
  task automatic apply_timer_item(input logic act, input sdtq_pkg::stamp_t ddl,
                                  input sdtq_pkg::stamp_t t_now,
                                  output timer_report_t rep);
    int                pos;
    int                gone;
    sdtq_pkg::status_t st;
    st   = sdtq_pkg::STAT_OK;
    pos  = 0;
    gone = 0;
    if (act == sdtq_pkg::ACT_ADD) begin
      if (ddl == '0) begin
        st = sdtq_pkg::STAT_ZERO;
      end else begin
        while (pos < held_cnt && held_ddl[pos] < ddl) pos++;
        if (pos < held_cnt && held_ddl[pos] == ddl) begin
          st = sdtq_pkg::STAT_DUP;
        end else if (held_cnt >= sdtq_pkg::QUEUE_DEPTH) begin
          st = sdtq_pkg::STAT_FULL;
        end else begin
          for (int j = held_cnt; j > pos; j--) held_ddl[j] = held_ddl[j-1];
          held_ddl[pos] = ddl;
          held_cnt++;
        end
      end
    end else begin
      while (gone < held_cnt && held_ddl[gone] <= t_now) gone++;
      for (int j = 0; j < held_cnt - gone; j++) held_ddl[j] = held_ddl[j+gone];
      held_cnt -= gone;
    end
    // the earliest held deadline is always the armed one
    armed_q     = (held_cnt > 0);
    armed_ddl_q = (held_cnt > 0) ? held_ddl[0] : '0;
    rep.armed_valid    = armed_q;
    rep.armed_deadline = armed_ddl_q;
    rep.status         = st;
    rep.expired_count  = sdtq_pkg::report_t'(gone);
    rep.pending_count  = sdtq_pkg::report_t'(held_cnt);
  endtask

  // compare finished results first, then queue the item taken at this edge
  always @(posedge clk) begin
    timer_report_t want;
    timer_report_t fresh;
    if (!rst_n) begin
      held_cnt    = 0;
      armed_q     = 1'b0;
      armed_ddl_q = '0;
      due_reports.delete();
      errs        = 0;
      checks      = 0;
      fulls       = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_reports.size() == 0) begin
          $error("result transfer with no report due");
          errs++;
        end else begin
          want = due_reports.pop_front();
          checks++;
          if (out_mon.armed_valid !== want.armed_valid) begin
            $error("armed_valid: expected %0d, actual %0d", want.armed_valid,
                   out_mon.armed_valid);
            errs++;
          end
          if (out_mon.armed_deadline !== want.armed_deadline) begin
            $error("armed_deadline: expected %0h, actual %0h", want.armed_deadline,
                   out_mon.armed_deadline);
            errs++;
          end
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_mon.status);
            errs++;
          end
          if (out_mon.expired_count !== want.expired_count) begin
            $error("expired_count: expected %0d, actual %0d", want.expired_count,
                   out_mon.expired_count);
            errs++;
          end
          if (out_mon.pending_count !== want.pending_count) begin
            $error("pending_count: expected %0d, actual %0d", want.pending_count,
                   out_mon.pending_count);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_timer_item(in_mon.action, in_mon.deadline, in_mon.now, fresh);
        if (fresh.status == sdtq_pkg::STAT_FULL) fulls++;
        due_reports.push_back(fresh);
      end
    end
    fail_count    <= errs;
    checked_count <= checks;
    full_count    <= fulls;
    outstanding   <= due_reports.size();
  end

endmodule

// File: tb/sorted_deadline_timer_queue_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_deadline_timer_queue_unit_tb
// Stimulus and verdict for the sorted deadline timer queue.
// ---------------------------------------------------------------------------
// A short directed run covers the empty, zero, duplicate and full cases and
// the boundary times, then a random run feeds deadlines around a moving
// current time with fires that expire a few or all of them, mixed with
// zero adds, repeats, wild values and fill bursts. Both channels idle in
// random bursts; the last part runs at full rate. Checking happens in
// sdtq_queue_check beside the block.
module sorted_deadline_timer_queue_unit_tb;

  logic clk = 1'b0;
  logic rst_n;
  logic sink_rdy = 1'b0;
  bit   idle_on;
  int   stall_left = 0;
  int   sent = 0;
  int   fail_count;
  int   outstanding;
  int   checked_count;
  int   full_count;

  sdtq_pkg::stamp_t cur_time;
  sdtq_pkg::stamp_t recent[$];

  sdtq_in_if  in_ch ();
  sdtq_out_if out_ch ();

  assign out_ch.ready = sink_rdy;

  sorted_deadline_timer_queue_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sdtq_queue_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .full_count    (full_count)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_rdy   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      sink_rdy   <= 1'b0;
    end else begin
      sink_rdy <= 1'b1;
    end
  end

  function automatic sdtq_pkg::stamp_t rand_stamp();
    return {$urandom(), $urandom()};
  endfunction

  // one item transfer, with an optional idle burst ahead of it
  task automatic send_item(input logic act, input sdtq_pkg::stamp_t ddl,
                           input sdtq_pkg::stamp_t tnow);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.deadline <= ddl;
    in_ch.now      <= tnow;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // unused field gets noise so the block must ignore it
  task automatic add_ddl(input sdtq_pkg::stamp_t d);
    send_item(sdtq_pkg::ACT_ADD, d, rand_stamp());
    if (d != '0) begin
      recent.push_back(d);
      if (recent.size() > 24) void'(recent.pop_front());
    end
  endtask

  task automatic fire_at(input sdtq_pkg::stamp_t t);
    send_item(sdtq_pkg::ACT_FIRE, rand_stamp(), t);
  endtask

  // mostly deadlines near the current time and fires that move it forward
  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      add_ddl(cur_time + 64'($urandom_range(1, 2000)));
    end else if (pick < 54) begin
      if (recent.size() > 0) add_ddl(recent[$urandom_range(0, recent.size() - 1)]);
      else add_ddl(cur_time + 64'd1);
    end else if (pick < 58) begin
      add_ddl('0);
    end else if (pick < 64) begin
      add_ddl(rand_stamp());
    end else if (pick < 88) begin
      cur_time += 64'($urandom_range(0, 1500));
      fire_at(cur_time);
    end else if (pick < 93) begin
      fire_at(rand_stamp());
    end else if (pick < 95) begin
      fire_at('1);
    end else begin
      fire_at(cur_time - 64'($urandom_range(0, 3000)));
    end
  endtask

  // wait until every report due has been seen
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    rst_n          <= 1'b0;
    idle_on        <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= sdtq_pkg::ACT_ADD;
    in_ch.deadline <= '0;
    in_ch.now      <= '0;
    cur_time        = 64'd100000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    fire_at('1);          // fire with nothing held
    add_ddl('0);          // zero deadline ignored
    add_ddl('1);          // largest deadline
    add_ddl(64'd1);       // smallest deadline
    add_ddl(64'd1);       // duplicate dropped
    add_ddl(64'd5000);
    add_ddl(64'd3000);    // earlier deadline goes in ahead of a later held one
    fire_at('0);          // nothing due yet
    fire_at(64'd1);
    fire_at(64'd3000);    // deadline equal to the time expires
    for (int k = 0; k < 14; k++) add_ddl(64'd10000 + 64'(k) * 64'd7);
    add_ddl(64'd20);      // store full
    add_ddl(64'd5000);    // held deadline in a full store reports duplicate
    fire_at('1);          // every deadline expires at once

    // random part
    for (int i = 0; i < 900; i++) begin
      if (i >= 740) idle_on <= 1'b0;
      else if (i % 150 == 0) idle_on <= ($urandom_range(0, 3) != 0);
      if (i == 500) drain();
      if (i % 120 == 60) begin
        // fill burst to reach the full store
        for (int k = 0; k < 20; k++) add_ddl(cur_time + 64'($urandom_range(1, 5000)));
      end
      if (i % 200 == 199) begin
        // new time epoch, sometimes close to the top of the range
        fire_at('1);
        cur_time = ($urandom_range(0, 1) == 0) ? rand_stamp() : 64'hFFFF_FFFF_FFFF_E000;
      end
      random_item();
    end

    drain();
    repeat (100) @(posedge clk);
    $display("%0d items sent, %0d results compared, %0d adds refused by a full store",
             sent, checked_count, full_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
